// ===== rtl/core/gddc_pkg.sv =====
// Shared types and constants for the grid density decay classifier.
// No dependencies; imported by gddc_cfg_regs, gddc_mul_unit and the top level.
`default_nettype none

package gddc_pkg;

  // Width of the stored update time (now_time is cut or padded to this)
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned IDX_W     = $clog2(TIME_BITS);

  // Q16.16 / Q0.16 constants
  localparam logic [16:0] ONE_Q16  = 17'h1_0000;
  localparam logic [47:0] HALF_Q16 = 48'h8000;

  // Commands
  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;
  localparam logic [1:0] CMD_RECLASS = 2'd3;

  // Cell classes
  localparam logic [1:0] CLS_SPARSE = 2'd0;
  localparam logic [1:0] CLS_TRANS  = 2'd1;
  localparam logic [1:0] CLS_DENSE  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_DECAY    = 2'd0;
  localparam logic [1:0] REG_SPARSE   = 2'd1;
  localparam logic [1:0] REG_DENSE    = 2'd2;
  localparam logic [1:0] REG_LANDMARK = 2'd3;

  // Register reset values
  localparam logic [15:0] DECAY_RST  = 16'd64880;
  localparam logic [31:0] SPARSE_RST = 32'd65536;
  localparam logic [31:0] DENSE_RST  = 32'd262144;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [15:0] decay_factor;
    logic [31:0] sparse_threshold;
    logic [31:0] dense_threshold;
    logic        landmark_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/gddc_cfg_regs.sv =====
// Configuration register file of the grid density decay classifier.
// Depends on gddc_pkg (register indexes, reset values, cfg_t).
`default_nettype none

module gddc_cfg_regs
  import gddc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are taken every cycle
  assign cfg_ready_o = 1'b1;

  // Decode of the write request
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DECAY:    cfg_d.decay_factor     = cfg_data_i[15:0];
        REG_SPARSE:   cfg_d.sparse_threshold = cfg_data_i;
        REG_DENSE:    cfg_d.dense_threshold  = cfg_data_i;
        REG_LANDMARK: cfg_d.landmark_mode    = cfg_data_i[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_factor     <= DECAY_RST;
      cfg_q.sparse_threshold <= SPARSE_RST;
      cfg_q.dense_threshold  <= DENSE_RST;
      cfg_q.landmark_mode    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/gddc_mul_unit.sv =====
// Shared Q16 multiply with round-to-nearest (halves up): (a*b + 0.5) >> 16.
// Depends on gddc_pkg (HALF_Q16). Result is registered by the caller.
`default_nettype none

module gddc_mul_unit
  import gddc_pkg::*;
(
  input  logic [31:0] op_a_i,
  input  logic [16:0] op_b_i,
  output logic [31:0] res_o
);

  logic [47:0] prod;
  logic [47:0] rnd;

  // A full 32x17 product needs 49 bits; it and the rounding add are kept to 48
  assign prod  = 48'(op_a_i) * 48'(op_b_i);
  assign rnd   = prod + HALF_Q16;
  assign res_o = rnd[47:16];

endmodule

`default_nettype wire

// ===== rtl/core/grid_density_decay_classifier_top.sv =====
// Top level of the grid density decay classifier: sequencer, cell state, classifier.
// Depends on gddc_pkg, gddc_cfg_regs and gddc_mul_unit.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+--------------------------------------
//  input    | in_valid_i   | in_ready_o   | cmd_i, now_time_i, init_density_i
//  result   | out_valid_o  | out_ready_i  | density_o, grid_class_o, class_changed_o
//  config   | cfg_valid_i  | cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Add-point and update in damped mode run the power loop (ST_PACC, ST_PSQR) first:
// each bit of dt costs one multiply for the power and one for squaring the base,
// all on the single multiplier, then ST_SCALE. Other requests skip to ST_APPLY.
// One request at a time; a new one is taken in the cycle its result is taken.
// Reset clears the cell to zero density, sparse class; no clearing pass is needed.
`default_nettype none

module grid_density_decay_classifier_top
  import gddc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] now_time_i,
  input  logic [31:0] init_density_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] density_o,
  output logic [1:0]  grid_class_o,
  output logic        class_changed_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PACC  = 3'd1;
  localparam logic [2:0] ST_PSQR  = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_CLASS = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIME_BITS - 1);

  function automatic logic [1:0] classify(input logic [31:0] d, input cfg_t c);
    logic [1:0] r;
    if (d <= c.sparse_threshold) begin
      r = CLS_SPARSE;
    end else if (d >= c.dense_threshold) begin
      r = CLS_DENSE;
    end else begin
      r = CLS_TRANS;
    end
    return r;
  endfunction

  cfg_t cfg;

  gddc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Control state
  logic [2:0]           state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  // Cell state
  logic [31:0]          dens_q, dens_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [1:0]           class_q, class_d;
  logic                 flag_q, flag_d;
  // Request payload and working registers
  logic [1:0]           cmd_q, cmd_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [31:0]          init_q, init_d;
  logic [TIME_BITS-1:0] dt_q, dt_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [16:0]          acc_q, acc_d;
  logic [15:0]          base_q, base_d;
  logic [31:0]          dec_q, dec_d;

  logic                 in_req;
  logic [TIME_BITS-1:0] now_t;
  logic [31:0]          mul_a;
  logic [16:0]          mul_b;
  logic [31:0]          mul_res;
  logic [32:0]          sum;
  logic [1:0]           cls_new;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_req     = in_valid_i && in_ready_o;
  assign now_t      = TIME_BITS'(now_time_i);

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state_q)
      ST_PACC:  begin mul_a = 32'(acc_q);  mul_b = 17'(base_q); end
      ST_PSQR:  begin mul_a = 32'(base_q); mul_b = 17'(base_q); end
      ST_SCALE: begin mul_a = dens_q;      mul_b = acc_q;       end
      default:  begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  gddc_mul_unit u_mul (
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .res_o  (mul_res)
  );

  assign sum     = 33'(dec_q) + 33'(ONE_Q16);
  assign cls_new = classify(dens_q, cfg);

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    dens_d      = dens_q;
    time_d      = time_q;
    class_d     = class_q;
    flag_d      = flag_q;
    cmd_d       = cmd_q;
    now_d       = now_q;
    init_d      = init_q;
    dt_d        = dt_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    base_d      = base_q;
    dec_d       = dec_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          cmd_d  = cmd_i;
          now_d  = now_t;
          init_d = init_density_i;
          dt_d   = (now_t >= time_q) ? (now_t - time_q) : '0;
          idx_d  = '0;
          acc_d  = ONE_Q16;
          base_d = cfg.decay_factor;
          dec_d  = dens_q;
          if ((cmd_i == CMD_ADD || cmd_i == CMD_UPDATE) && !cfg.landmark_mode) begin
            state_d = ST_PACC;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      // Multiply the power by the base where this bit of dt is set
      ST_PACC: begin
        if (dt_q[idx_q]) begin
          acc_d = mul_res[16:0];
        end
        state_d = ST_PSQR;
      end
      // Square the base; step to the next bit
      ST_PSQR: begin
        base_d = mul_res[15:0];
        if (idx_q == LAST_IDX) begin
          state_d = ST_SCALE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_PACC;
        end
      end
      // Decayed density = density * power
      ST_SCALE: begin
        dec_d   = mul_res;
        state_d = ST_APPLY;
      end
      // Density and time update per command
      ST_APPLY: begin
        unique case (cmd_q)
          CMD_INIT: begin
            dens_d = init_q;
            time_d = now_q;
          end
          CMD_ADD: begin
            dens_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            time_d = now_q;
          end
          CMD_UPDATE: begin
            dens_d = dec_q;
            time_d = now_q;
          end
          default: ;
        endcase
        state_d = ST_CLASS;
      end
      // Classify (not for add-point) and post the result
      ST_CLASS: begin
        unique case (cmd_q)
          CMD_INIT: begin
            class_d = cls_new;
            flag_d  = 1'b0;
          end
          CMD_UPDATE: begin
            class_d = cls_new;
            flag_d  = (cls_new != class_q);
          end
          CMD_RECLASS: class_d = cls_new;
          default: ;
        endcase
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and cell state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dens_q      <= '0;
      time_q      <= '0;
      class_q     <= CLS_SPARSE;
      flag_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dens_q      <= dens_d;
      time_q      <= time_d;
      class_q     <= class_d;
      flag_q      <= flag_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    now_q  <= now_d;
    init_q <= init_d;
    dt_q   <= dt_d;
    idx_q  <= idx_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    dec_q  <= dec_d;
  end

  // Cell state holds until the next request, so it drives the result directly
  assign out_valid_o     = out_valid_q;
  assign density_o       = dens_q;
  assign grid_class_o    = class_q;
  assign class_changed_o = flag_q;

endmodule

`default_nettype wire

// ===== rtl/core/gddc_checker.sv =====
// Port-level checker for the grid density decay classifier, with its bind.
// Depends only on the ports of grid_density_decay_classifier_top.
`default_nettype none

module gddc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [31:0] density_o,
  input wire [1:0]  grid_class_o,
  input wire        class_changed_o
);

  // A pending result stays, unchanged, until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(density_o)
      && $stable(grid_class_o) && $stable(class_changed_o))
    else $error("result dropped or changed while stalled");

  // No request is taken over a result that is still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("request taken while a result waits");

  // A result never appears in the cycle right after a request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result too early");

  // One result per request: a taken result is not shown again
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind grid_density_decay_classifier_top gddc_checker u_gddc_checker (.*);

`default_nettype wire
